### design/ppht_pkg.sv
package ppht_pkg;

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 13;
  localparam int WIN_W   = 12;
  localparam int CUR_W   = 8;
  localparam int HEAD_W  = 10;
  localparam int CFG_IDX_W = 2;

  localparam logic [CMD_W-1:0] CMD_MOVE_X = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE_Y = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET_X  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_Y  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_H = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_W = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_H = 2'd3;

  localparam int RST_WIN_W = 800;
  localparam int RST_WIN_H = 600;
  localparam int RST_CUR_W = 22;
  localparam int RST_CUR_H = 29;
  localparam int RST_X     = RST_WIN_W / 2;
  localparam int RST_Y     = RST_WIN_H / 2;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_SCALE = 20;
  localparam int STEP_W       = 5;
  localparam int ATAN_W       = 22;
  localparam int ANG_W        = 26;
  localparam int ANG_FRAC     = 16;
  localparam int ANG_HALF     = 1 << (ANG_FRAC - 1);
  localparam int HALF_TURN    = 180 << ANG_FRAC;
  localparam int HEAD_OFFSET  = 90;

  typedef struct packed {
    logic              latch;
    logic              commit;
    logic              start;
    logic              step;
    logic [STEP_W-1:0] step_idx;
    logic              finish;
  } ppht_cmd_t;

  typedef struct packed {
    logic is_update;
    logic sums_zero;
  } ppht_stat_t;

  function automatic logic [ATAN_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] r;
    case (idx)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740968;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      5'd20:   r = 22'd4;
      5'd21:   r = 22'd2;
      5'd22:   r = 22'd1;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

### design/ppht_in_if.sv
interface ppht_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [ppht_pkg::CMD_W-1:0]     command;
  logic signed [ppht_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

### design/ppht_out_if.sv
interface ppht_out_if #(
  parameter int POS_W = 12
);
  logic                                valid;
  logic                                ready;
  logic        [POS_W-1:0]             x_pos;
  logic        [POS_W-1:0]             y_pos;
  logic signed [ppht_pkg::HEAD_W-1:0]  heading_deg;

  modport source (output valid, output x_pos, output y_pos, output heading_deg, input ready);
  modport sink (input valid, input x_pos, input y_pos, input heading_deg, output ready);
endinterface

### design/ppht_cfg_if.sv
interface ppht_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ppht_pkg::CFG_IDX_W-1:0]    index;
  logic [ppht_pkg::WIN_W-1:0]        data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/ppht_ram.sv
module ppht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/ppht_ctrl.sv
module ppht_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ppht_pkg::ppht_stat_t  stat,
  output ppht_pkg::ppht_cmd_t   cmd
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_ITER, S_FIN} state_t;

  localparam logic [ppht_pkg::STEP_W-1:0] LAST_STEP =
    ppht_pkg::STEP_W'(ppht_pkg::CORDIC_STEPS - 1);

  state_t                        state_r, state_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ppht_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          can_load;

  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    cmd.step_idx = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.is_update && !stat.sums_zero) begin
          cmd.start = 1'b1;
          step_nxt  = '0;
          state_nxt = S_ITER;
        end else if (can_load) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_ITER: begin
        cmd.step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (can_load) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.commit || cmd.finish;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/ppht_dp.sv
module ppht_dp #(
  parameter int HISTORY_DEPTH = 8,
  parameter int POSITION_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  ppht_pkg::ppht_cmd_t                    cmd,
  output ppht_pkg::ppht_stat_t                   stat,
  input  logic        [ppht_pkg::CMD_W-1:0]      in_command,
  input  logic signed [ppht_pkg::VALUE_W-1:0]    in_value,
  input  logic                                   cfg_we,
  input  logic        [ppht_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [ppht_pkg::WIN_W-1:0]      cfg_data,
  output logic        [POSITION_BITS-1:0]        x_pos,
  output logic        [POSITION_BITS-1:0]        y_pos,
  output logic signed [ppht_pkg::HEAD_W-1:0]     heading_deg
);

  localparam int VW     = ppht_pkg::VALUE_W;
  localparam int PB     = POSITION_BITS;
  localparam int SW     = (PB > VW ? PB : VW) + 2;
  localparam int SLOT_W = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W  = VW + $clog2(HISTORY_DEPTH);
  localparam int CW     = SUM_W + ppht_pkg::CORDIC_SCALE + 3;
  localparam int ZW     = ppht_pkg::ANG_W;
  localparam int HW     = ppht_pkg::HEAD_W;
  localparam logic signed [SW-1:0] POS_TOP = SW'((1 << PB) - 1);
  localparam logic signed [SW-1:0] ZERO_S  = '0;
  localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  function automatic logic [PB-1:0] clamp_pos(input logic signed [SW-1:0] p,
                                               input logic signed [SW-1:0] lo,
                                               input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] q;
    q = p;
    if (q < lo) begin
      q = lo;
    end else if (q > hi) begin
      q = hi;
    end
    if (q[SW-1]) begin
      return '0;
    end
    if (q > POS_TOP) begin
      return '1;
    end
    return q[PB-1:0];
  endfunction

  logic        [ppht_pkg::CMD_W-1:0]   cmd_r;
  logic signed [VW-1:0]                val_r;
  logic        [ppht_pkg::WIN_W-1:0]   win_w_r, win_h_r;
  logic        [ppht_pkg::CUR_W-1:0]   cur_w_r, cur_h_r;
  logic        [PB-1:0]                x_r, y_r, x_nxt, y_nxt;
  logic        [SLOT_W-1:0]            slot_r, slot_nxt;
  logic        [HISTORY_DEPTH-1:0]     vld_r;
  logic signed [SUM_W-1:0]             xsum_r, ysum_r, xsum_nxt, ysum_nxt;
  logic signed [HW-1:0]                heading_r, head_nxt, fin_head;
  logic        [PB-1:0]                ox_r, oy_r;
  logic signed [HW-1:0]                oh_r;
  logic signed [CW-1:0]                cx_r, cy_r, cx0, cy0, cxe, cye, xs, ys;
  logic signed [ZW-1:0]                cz_r, cz0, at, mag, rnd;
  logic        [HW-1:0]                deg;
  logic                                hist_we;
  logic signed [VW-1:0]                dx, dy, old_x, old_y;
  logic        [2*VW-1:0]              hist_rdata;
  logic signed [SW-1:0]                v_ext, x_ext, y_ext, half, ww, wh, ch;

  ppht_ram #(
    .WIDTH (2 * VW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.commit && hist_we),
    .waddr (slot_r),
    .wdata ({dx, dy}),
    .raddr (slot_r),
    .rdata (hist_rdata)
  );

  assign v_ext = SW'(val_r);
  assign x_ext = $signed({{(SW - PB){1'b0}}, x_r});
  assign y_ext = $signed({{(SW - PB){1'b0}}, y_r});
  assign half  = $signed({{(SW - ppht_pkg::CUR_W + 1){1'b0}}, cur_w_r[ppht_pkg::CUR_W-1:1]});
  assign ww    = $signed({{(SW - ppht_pkg::WIN_W){1'b0}}, win_w_r});
  assign wh    = $signed({{(SW - ppht_pkg::WIN_W){1'b0}}, win_h_r});
  assign ch    = $signed({{(SW - ppht_pkg::CUR_W){1'b0}}, cur_h_r});

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    head_nxt = heading_r;
    hist_we  = 1'b0;
    dx       = '0;
    dy       = '0;
    case (cmd_r)
      ppht_pkg::CMD_MOVE_X: begin
        x_nxt   = clamp_pos(x_ext + v_ext, half, ww - half);
        hist_we = 1'b1;
        dx      = val_r;
      end
      ppht_pkg::CMD_MOVE_Y: begin
        y_nxt   = clamp_pos(y_ext + v_ext, ZERO_S, wh - ch);
        hist_we = 1'b1;
        dy      = val_r;
      end
      ppht_pkg::CMD_SET_X: begin
        x_nxt = clamp_pos(v_ext, ZERO_S, ww);
      end
      ppht_pkg::CMD_SET_Y: begin
        y_nxt = clamp_pos(v_ext, ZERO_S, wh);
      end
      ppht_pkg::CMD_UPDATE: begin
        head_nxt = HW'(ppht_pkg::HEAD_OFFSET);
      end
      default: begin
      end
    endcase
  end

  assign old_x    = vld_r[slot_r] ? $signed(hist_rdata[2*VW-1:VW]) : '0;
  assign old_y    = vld_r[slot_r] ? $signed(hist_rdata[VW-1:0]) : '0;
  assign xsum_nxt = xsum_r + SUM_W'(dx) - SUM_W'(old_x);
  assign ysum_nxt = ysum_r + SUM_W'(dy) - SUM_W'(old_y);
  assign slot_nxt = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;

  assign cxe = CW'(xsum_r);
  assign cye = CW'(ysum_r);
  assign cx0 = (xsum_r[SUM_W-1] ? -cxe : cxe) <<< ppht_pkg::CORDIC_SCALE;
  assign cy0 = (xsum_r[SUM_W-1] ? -cye : cye) <<< ppht_pkg::CORDIC_SCALE;
  assign cz0 = !xsum_r[SUM_W-1] ? '0 :
               (!ysum_r[SUM_W-1] ? $signed(ZW'(ppht_pkg::HALF_TURN))
                                 : -$signed(ZW'(ppht_pkg::HALF_TURN)));

  assign xs = cx_r >>> cmd.step_idx;
  assign ys = cy_r >>> cmd.step_idx;
  assign at = $signed(ZW'(ppht_pkg::atan_lut(cmd.step_idx)));

  assign mag      = cz_r[ZW-1] ? -cz_r : cz_r;
  assign rnd      = mag + ZW'(ppht_pkg::ANG_HALF);
  assign deg      = rnd[ppht_pkg::ANG_FRAC+HW-1:ppht_pkg::ANG_FRAC];
  assign fin_head = (cz_r[ZW-1] ? -$signed(deg) : $signed(deg)) + HW'(ppht_pkg::HEAD_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_w_r   <= ppht_pkg::WIN_W'(ppht_pkg::RST_WIN_W);
      win_h_r   <= ppht_pkg::WIN_W'(ppht_pkg::RST_WIN_H);
      cur_w_r   <= ppht_pkg::CUR_W'(ppht_pkg::RST_CUR_W);
      cur_h_r   <= ppht_pkg::CUR_W'(ppht_pkg::RST_CUR_H);
      x_r       <= PB'(ppht_pkg::RST_X);
      y_r       <= PB'(ppht_pkg::RST_Y);
      slot_r    <= '0;
      vld_r     <= '0;
      xsum_r    <= '0;
      ysum_r    <= '0;
      heading_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ppht_pkg::REG_WIN_W: win_w_r <= cfg_data;
          ppht_pkg::REG_WIN_H: win_h_r <= cfg_data;
          ppht_pkg::REG_CUR_W: cur_w_r <= cfg_data[ppht_pkg::CUR_W-1:0];
          ppht_pkg::REG_CUR_H: cur_h_r <= cfg_data[ppht_pkg::CUR_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        x_r       <= x_nxt;
        y_r       <= y_nxt;
        heading_r <= head_nxt;
        if (hist_we) begin
          xsum_r        <= xsum_nxt;
          ysum_r        <= ysum_nxt;
          vld_r[slot_r] <= 1'b1;
          slot_r        <= slot_nxt;
        end
      end
      if (cmd.finish) begin
        heading_r <= fin_head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
    if (cmd.start) begin
      cx_r <= cx0;
      cy_r <= cy0;
      cz_r <= cz0;
    end else if (cmd.step) begin
      if (cy_r > 0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + at;
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - at;
      end
    end
    if (cmd.commit) begin
      ox_r <= x_nxt;
      oy_r <= y_nxt;
      oh_r <= head_nxt;
    end else if (cmd.finish) begin
      ox_r <= x_r;
      oy_r <= y_r;
      oh_r <= fin_head;
    end
  end

  assign stat.is_update = (cmd_r == ppht_pkg::CMD_UPDATE);
  assign stat.sums_zero = (xsum_r == '0) && (ysum_r == '0);
  assign x_pos          = ox_r;
  assign y_pos          = oy_r;
  assign heading_deg    = oh_r;

endmodule

### design/pointer_position_heading_tracker.sv
// Tracks a pointer position from move and set commands and, on an update
// command, computes a heading from the sums of the last HISTORY_DEPTH moves.
// An item is taken only while the block is idle. A move, set or unused
// command, or an update whose window sums are both zero, is executed in the
// execute state once the result register is free or being taken, and its
// result is registered there; the next item is taken once the block is back
// in idle. An update whose window sums are not both zero runs a 24-iteration
// CORDIC through one shift-add unit: the execute state loads the CORDIC
// registers, the iteration state runs the steps, and the finish state loads
// the result once the result register is free or being taken. The result
// register holds a finished result until it is taken, and the next item may
// be accepted meanwhile. Configuration writes are always accepted and should be made while no item is in flight.
module pointer_position_heading_tracker #(
  parameter int HISTORY_DEPTH = 8,
  parameter int POSITION_BITS = 12
) (
  input  logic       clk,
  input  logic       rst_n,
  ppht_in_if.sink    in_ch,
  ppht_out_if.source out_ch,
  ppht_cfg_if.sink   cfg_ch
);

  ppht_pkg::ppht_cmd_t  cmd;
  ppht_pkg::ppht_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ppht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ppht_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_command  (in_ch.command),
    .in_value    (in_ch.value),
    .cfg_we      (cfg_ch.valid),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .x_pos       (out_ch.x_pos),
    .y_pos       (out_ch.y_pos),
    .heading_deg (out_ch.heading_deg)
  );

endmodule
